/* rtl/core/binary_trie_max_xor_unit_assert.svh */
// Assertion macros for the binary trie maximum-xor unit.
`ifndef BINARY_TRIE_MAX_XOR_UNIT_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BTMX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btmx check failed");

// Next-cycle implication, checked while out of reset.
`define BTMX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btmx check failed");

`endif

/* rtl/core/btmx_pkg.sv */
// Package: constants, types and helpers of the binary trie maximum-xor unit.
package btmx_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_COUNT = 65536;
  localparam int KEY_W      = 32;
  localparam int ENTRY_W    = 32;
  localparam int PTR_W      = 16;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LVL_W      = $clog2(KEY_BITS);
  localparam int NEED_W     = LVL_W + 1;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_ALLOC,
    ST_LEAF,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] child_of(logic [ENTRY_W-1:0] entry, logic sel);
    child_of = sel ? entry[ENTRY_W-1:PTR_W] : entry[PTR_W-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] set_child(logic [ENTRY_W-1:0] entry, logic sel,
                                                   logic [PTR_W-1:0] child);
    logic [ENTRY_W-1:0] res;
    res = entry;
    if (sel) begin
      res[ENTRY_W-1:PTR_W] = child;
    end else begin
      res[PTR_W-1:0] = child;
    end
    set_child = res;
  endfunction

endpackage

/* rtl/core/btmx_node_ram.sv */
// Node child-pointer memory: one write port, one registered read port.
module btmx_node_ram (
  input  logic                              clk_i,
  input  btmx_pkg::ram_req_t                req_i,
  output logic [btmx_pkg::ENTRY_W-1:0]      rdata_o
);

  logic [btmx_pkg::ENTRY_W-1:0] mem_q [btmx_pkg::NODE_COUNT];
  logic [btmx_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/binary_trie_max_xor_unit.sv */
// Top level: binary trie with insert and maximum-xor query over a bounded node pool.
//
// Input channel: in_valid_i / in_stall_o carry one request (command_i, key_i).
// Command insert adds the key; command query returns key xor the stored key
// that maximizes it. Output channel: out_valid_o / out_stall_i carry status_o
// and xor_result_o, exactly one result per request, in request order.
// One request is in flight at a time; in_stall_o is high from acceptance
// until the result has moved into the output register.
// The walk visits one trie level per cycle through the node memory read port.
// Query: walk, then output; a dead end ends the walk early, and a query on an
// empty trie skips the walk. Insert: walk, check, allocation, leaf, output,
// where L levels already exist on the key's path and N = 32 - L nodes are
// allocated; a duplicate key skips check and allocation; a refused insert
// skips allocation and leaf.
// Each allocated level writes one entry (the root register for the root node,
// else the node memory); the leaf state writes one more memory entry.
// The output register holds a result while out_stall_i is high; a new request
// is taken meanwhile, and its result waits in the unit until the register frees.
// Reset empties the trie at once: root pointers cleared, one node used, no keys.
module binary_trie_max_xor_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [btmx_pkg::KEY_W-1:0]   key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [btmx_pkg::KEY_W-1:0]   xor_result_o
);

  btmx_pkg::state_e state_q, state_d;

  logic                            cmd_q, cmd_d;
  logic [btmx_pkg::KEY_W-1:0]      key_q, key_d;
  logic [btmx_pkg::KEY_W-1:0]      partner_q, partner_d;
  logic [btmx_pkg::LVL_W-1:0]      level_q, level_d;
  logic [btmx_pkg::IDX_W-1:0]      node_q, node_d;
  logic [btmx_pkg::ENTRY_W-1:0]    ent_q, ent_d;
  logic [btmx_pkg::ENTRY_W-1:0]    root_q, root_d;
  logic [btmx_pkg::CNT_W-1:0]      used_q, used_d;
  logic                            has_keys_q, has_keys_d;
  logic [1:0]                      res_status_q, res_status_d;
  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      status_q, status_d;
  logic [btmx_pkg::KEY_W-1:0]      xor_q, xor_d;

  btmx_pkg::ram_req_t              ram_req;
  logic [btmx_pkg::ENTRY_W-1:0]    ram_rdata;

  logic                            in_acc;
  logic                            out_free;
  logic [btmx_pkg::ENTRY_W-1:0]    cur_entry;
  logic                            kbit;
  logic [btmx_pkg::PTR_W-1:0]      c_same;
  logic [btmx_pkg::PTR_W-1:0]      c_other;
  logic [btmx_pkg::PTR_W-1:0]      c_next;
  logic                            c_ok;
  logic                            taken;
  logic                            level_zero;
  logic [btmx_pkg::NEED_W-1:0]     needed;
  logic [btmx_pkg::CNT_W-1:0]      free_cnt;
  logic                            pool_full;
  logic [btmx_pkg::ENTRY_W-1:0]    alloc_entry;
  logic                            alloc_phase;

  btmx_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != btmx_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cur_entry  = (node_q == '0) ? root_q : ram_rdata;
  assign kbit       = key_q[level_q];
  assign c_same     = btmx_pkg::child_of(cur_entry, kbit);
  assign c_other    = btmx_pkg::child_of(cur_entry, !kbit);
  assign level_zero = (level_q == '0);

  always_comb begin
    if (cmd_q == btmx_pkg::CMD_QUERY) begin
      if (c_other != '0) begin
        c_next = c_other;
        taken  = !kbit;
      end else begin
        c_next = c_same;
        taken  = kbit;
      end
    end else begin
      c_next = c_same;
      taken  = kbit;
    end
  end
  assign c_ok = (c_next != '0);

  assign needed      = {1'b0, level_q} + btmx_pkg::NEED_W'(1);
  assign free_cnt    = btmx_pkg::CNT_W'(btmx_pkg::NODE_COUNT) - used_q;
  assign pool_full   = btmx_pkg::CNT_W'(needed) > free_cnt;
  assign alloc_entry = btmx_pkg::set_child(ent_q, kbit, btmx_pkg::PTR_W'(used_q));
  assign alloc_phase = (state_q == btmx_pkg::ST_ALLOC) || (state_q == btmx_pkg::ST_LEAF);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      btmx_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (command_i == btmx_pkg::CMD_QUERY && !has_keys_q) begin
            state_d = btmx_pkg::ST_RESP;
          end else begin
            state_d = btmx_pkg::ST_WALK;
          end
        end
      end
      btmx_pkg::ST_WALK: begin
        if (!c_ok) begin
          state_d = (cmd_q == btmx_pkg::CMD_QUERY) ? btmx_pkg::ST_RESP : btmx_pkg::ST_CHECK;
        end else if (level_zero) begin
          state_d = btmx_pkg::ST_RESP;
        end
      end
      btmx_pkg::ST_CHECK: begin
        state_d = pool_full ? btmx_pkg::ST_RESP : btmx_pkg::ST_ALLOC;
      end
      btmx_pkg::ST_ALLOC: begin
        if (level_zero) begin
          state_d = btmx_pkg::ST_LEAF;
        end
      end
      btmx_pkg::ST_LEAF: begin
        state_d = btmx_pkg::ST_RESP;
      end
      btmx_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = btmx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = btmx_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cmd_d        = cmd_q;
    key_d        = key_q;
    partner_d    = partner_q;
    level_d      = level_q;
    node_d       = node_q;
    ent_d        = ent_q;
    root_d       = root_q;
    used_d       = used_q;
    has_keys_d   = has_keys_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    xor_d        = xor_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = node_q;
    ram_req.wdata = alloc_entry;
    ram_req.raddr = c_next[btmx_pkg::IDX_W-1:0];
    case (state_q)
      btmx_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_d        = command_i;
          key_d        = key_i & btmx_pkg::KEY_MASK;
          partner_d    = '0;
          level_d      = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
          node_d       = '0;
          res_status_d = (command_i == btmx_pkg::CMD_QUERY && !has_keys_q) ?
                         btmx_pkg::STATUS_EMPTY : btmx_pkg::STATUS_OK;
        end
      end
      btmx_pkg::ST_WALK: begin
        if (!c_ok) begin
          ent_d = cur_entry;
        end else begin
          partner_d[level_q] = taken;
          if (level_zero) begin
            if (cmd_q == btmx_pkg::CMD_INSERT) begin
              has_keys_d = 1'b1;
            end
          end else begin
            node_d  = c_next[btmx_pkg::IDX_W-1:0];
            level_d = level_q - btmx_pkg::LVL_W'(1);
          end
        end
      end
      btmx_pkg::ST_CHECK: begin
        if (pool_full) begin
          res_status_d = btmx_pkg::STATUS_FULL;
        end
      end
      btmx_pkg::ST_ALLOC: begin
        if (node_q == '0) begin
          root_d = alloc_entry;
        end else begin
          ram_req.we = 1'b1;
        end
        node_d = used_q[btmx_pkg::IDX_W-1:0];
        used_d = used_q + btmx_pkg::CNT_W'(1);
        ent_d  = '0;
        if (!level_zero) begin
          level_d = level_q - btmx_pkg::LVL_W'(1);
        end
      end
      btmx_pkg::ST_LEAF: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '0;
        has_keys_d    = 1'b1;
      end
      btmx_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          xor_d       = (cmd_q == btmx_pkg::CMD_QUERY && res_status_q == btmx_pkg::STATUS_OK) ?
                        ((key_q ^ partner_q) & btmx_pkg::KEY_MASK) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btmx_pkg::ST_IDLE;
      root_q      <= '0;
      used_q      <= btmx_pkg::CNT_W'(1);
      has_keys_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_q      <= root_d;
      used_q      <= used_d;
      has_keys_q  <= has_keys_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    partner_q    <= partner_d;
    level_q      <= level_d;
    node_q       <= node_d;
    ent_q        <= ent_d;
    res_status_q <= res_status_d;
    status_q     <= status_d;
    xor_q        <= xor_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign xor_result_o = xor_q;

`include "binary_trie_max_xor_unit_assert.svh"

  `BTMX_ASSERT_IMP(a_pool_bound, 1'b1, used_q <= btmx_pkg::CNT_W'(btmx_pkg::NODE_COUNT))
  `BTMX_ASSERT_IMP(a_write_alloc_only, ram_req.we, alloc_phase)
  `BTMX_ASSERT_NXT(a_full_keeps_pool, state_q == btmx_pkg::ST_CHECK && pool_full, $stable(used_q))
  `BTMX_ASSERT_IMP(a_non_ok_zero, out_valid_q && status_q != btmx_pkg::STATUS_OK, xor_q == '0)

endmodule
